// ===== design/faar_pkg.sv =====
// shared constants, types and helpers for the fraction adder with reduction
// no dependencies; used by every module of the block
package faar_pkg;

  localparam int OperandWidth = 16;
  localparam int InW          = 16;
  localparam int NumW         = 33;
  localparam int DenW         = 32;
  localparam int ExtW         = 17;
  localparam int ProdW        = 2 * ExtW;
  localparam int MagW         = 33;
  localparam int CntW         = $clog2(MagW);
  localparam int InDataW      = 4 * InW;
  localparam int OutDataW     = ((NumW + DenW + 7) / 8) * 8;
  localparam int OutPadW      = OutDataW - NumW - DenW;

  localparam bit SignExt = (OperandWidth <= InW);
  localparam int SignPos = SignExt ? OperandWidth - 1 : InW;
  localparam int SignIdx = SignExt ? OperandWidth - 1 : 0;

  typedef logic signed [ExtW-1:0]  ext_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic [MagW-1:0]         mag_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic check;
    logic gcd_step;
    logic gcd_fin;
    logic div_step;
    logic out_load;
  } faar_cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } faar_sts_t;

  // sign-extend an input field at the operand width
  function automatic ext_t widen(logic [InW-1:0] raw);
    ext_t v;
    for (int i = 0; i < ExtW; i++) begin
      if (i < SignPos && i < InW) begin
        v[i] = raw[i];
      end else begin
        v[i] = SignExt ? raw[SignIdx] : 1'b0;
      end
    end
    return v;
  endfunction

endpackage

// ===== design/fraction_add_and_reduce.sv =====
// top level of the fraction adder with reduction to lowest terms
// depends on faar_pkg, faar_ctrl and faar_dp
//
// usage:
//   input stream carries two signed fractions a_num/a_den and b_num/b_den;
//   the block returns (a_num*b_den + b_num*a_den) / (a_den*b_den) reduced
//   by the gcd of the magnitudes, signs kept on numerator and denominator
//   one result transfer per input transfer, in order
//   zero denominator product gives 0/0 with tuser high; zero numerator 0/1
//   a zero numerator or denominator skips the gcd and divide steps: load,
//   multiply, check and output; otherwise the binary gcd loop (one shift or
//   subtract-and-halve per cycle) and the restoring dividers that run both
//   quotients side by side follow the check; the next input is taken in the
//   cycle after the output step
//   one item is in work at a time; s_axis_tready is high only while idle
//   the finished result sits in an output register, so the next item is
//   taken while the receiver stalls; that item waits before its output step
//   reset clears the controller and drops any pending result
module fraction_add_and_reduce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [faar_pkg::InDataW-1:0]      s_axis_tdata,  // a_num, a_den, b_num, b_den
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [faar_pkg::OutDataW-1:0]     m_axis_tdata,  // out_num, out_den, zero pad
  output logic                              m_axis_tuser   // zero_den_error
);

  faar_pkg::faar_cmd_t cmd;
  faar_pkg::faar_sts_t sts;
  logic signed [faar_pkg::NumW-1:0] out_num;
  logic signed [faar_pkg::DenW-1:0] out_den;

  faar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  faar_dp u_dp (
    .clk_i     (clk_i),
    .in_data_i (s_axis_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_num_o (out_num),
    .out_den_o (out_den),
    .out_err_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{faar_pkg::OutPadW{1'b0}}, out_den, out_num};

endmodule

// ===== design/faar_ctrl.sv =====
// controller state machine of the fraction adder: sequences load, multiply,
// gcd, divide and output; depends on faar_pkg
module faar_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  faar_pkg::faar_sts_t sts_i,
  output faar_pkg::faar_cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StGcd  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StChk;
      end
      StChk: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.special ? StOut : StGcd;
      end
      StGcd: begin
        if (sts_i.gcd_done) begin
          cmd_o.gcd_fin = 1'b1;
          state_d       = StDiv;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_o.out_load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = valid_q;

endmodule

// ===== design/faar_dp.sv =====
// datapath of the fraction adder: cross products, binary gcd, two restoring
// dividers and the output register; depends on faar_pkg
module faar_dp (
  input  logic                              clk_i,
  input  logic [faar_pkg::InDataW-1:0]      in_data_i,
  input  faar_pkg::faar_cmd_t               cmd_i,
  output faar_pkg::faar_sts_t               sts_o,
  output logic signed [faar_pkg::NumW-1:0]  out_num_o,
  output logic signed [faar_pkg::DenW-1:0]  out_den_o,
  output logic                              out_err_o
);

  typedef struct packed {
    faar_pkg::mag_t rem;
    faar_pkg::mag_t quo;
  } div_t;

  // one restoring division step
  function automatic div_t div_iter(faar_pkg::mag_t rem, faar_pkg::mag_t quo,
                                    faar_pkg::mag_t dvs);
    logic [faar_pkg::MagW:0] shifted;
    logic [faar_pkg::MagW:0] diff;
    div_t r;
    shifted = {rem, quo[faar_pkg::MagW-1]};
    diff    = shifted - {1'b0, dvs};
    if (!diff[faar_pkg::MagW]) begin
      r.rem = diff[faar_pkg::MagW-1:0];
      r.quo = {quo[faar_pkg::MagW-2:0], 1'b1};
    end else begin
      r.rem = shifted[faar_pkg::MagW-1:0];
      r.quo = {quo[faar_pkg::MagW-2:0], 1'b0};
    end
    return r;
  endfunction

  faar_pkg::ext_t  an_q, ad_q, bn_q, bd_q;
  faar_pkg::prod_t num_q, den_q;
  faar_pkg::mag_t  x_q, y_q, g_q, qn_q, qd_q, rn_q, rd_q;
  logic [faar_pkg::CntW-1:0] k_q, cnt_q;
  logic neg_num_q, neg_den_q, err_q;
  logic signed [faar_pkg::NumW-1:0] out_num_q;
  logic signed [faar_pkg::DenW-1:0] out_den_q;
  logic out_err_q;

  faar_pkg::prod_t p_ab, p_ba, p_dd;
  logic [faar_pkg::ProdW-1:0] num_abs, den_abs;
  faar_pkg::mag_t qn_neg, qd_neg;
  div_t dn, dd;

  assign p_ab = an_q * bd_q;
  assign p_ba = bn_q * ad_q;
  assign p_dd = ad_q * bd_q;

  assign num_abs = num_q[faar_pkg::ProdW-1] ? '0 - num_q : num_q;
  assign den_abs = den_q[faar_pkg::ProdW-1] ? '0 - den_q : den_q;

  assign dn = div_iter(rn_q, qn_q, g_q);
  assign dd = div_iter(rd_q, qd_q, g_q);

  assign qn_neg = '0 - qn_q;
  assign qd_neg = '0 - qd_q;

  assign sts_o.special  = (num_q == '0) || (den_q == '0);
  assign sts_o.gcd_done = (x_q == y_q);
  assign sts_o.div_done = (cnt_q == faar_pkg::CntW'(faar_pkg::MagW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      an_q <= faar_pkg::widen(in_data_i[faar_pkg::InW-1:0]);
      ad_q <= faar_pkg::widen(in_data_i[2*faar_pkg::InW-1:faar_pkg::InW]);
      bn_q <= faar_pkg::widen(in_data_i[3*faar_pkg::InW-1:2*faar_pkg::InW]);
      bd_q <= faar_pkg::widen(in_data_i[4*faar_pkg::InW-1:3*faar_pkg::InW]);
    end

    if (cmd_i.mul) begin
      num_q <= p_ab + p_ba;
      den_q <= p_dd;
    end

    if (cmd_i.check) begin
      if (den_q == '0) begin
        qn_q      <= '0;
        qd_q      <= '0;
        err_q     <= 1'b1;
        neg_num_q <= 1'b0;
        neg_den_q <= 1'b0;
      end else if (num_q == '0) begin
        qn_q      <= '0;
        qd_q      <= faar_pkg::MagW'(1);
        err_q     <= 1'b0;
        neg_num_q <= 1'b0;
        neg_den_q <= 1'b0;
      end else begin
        qn_q      <= num_abs[faar_pkg::MagW-1:0];
        qd_q      <= den_abs[faar_pkg::MagW-1:0];
        x_q       <= num_abs[faar_pkg::MagW-1:0];
        y_q       <= den_abs[faar_pkg::MagW-1:0];
        k_q       <= '0;
        err_q     <= 1'b0;
        neg_num_q <= num_q[faar_pkg::ProdW-1];
        neg_den_q <= den_q[faar_pkg::ProdW-1];
      end
    end

    // binary gcd, difference of two odd values halved in the same step
    if (cmd_i.gcd_step) begin
      if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q > y_q) begin
        x_q <= (x_q - y_q) >> 1;
      end else begin
        y_q <= (y_q - x_q) >> 1;
      end
    end

    if (cmd_i.gcd_fin) begin
      g_q   <= x_q << k_q;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end

    if (cmd_i.div_step) begin
      rn_q  <= dn.rem;
      qn_q  <= dn.quo;
      rd_q  <= dd.rem;
      qd_q  <= dd.quo;
      cnt_q <= cnt_q + 1'b1;
    end

    if (cmd_i.out_load) begin
      out_num_q <= neg_num_q ? qn_neg[faar_pkg::NumW-1:0] : qn_q[faar_pkg::NumW-1:0];
      out_den_q <= neg_den_q ? qd_neg[faar_pkg::DenW-1:0] : qd_q[faar_pkg::DenW-1:0];
      out_err_q <= err_q;
    end
  end

  assign out_num_o = out_num_q;
  assign out_den_o = out_den_q;
  assign out_err_o = out_err_q;

endmodule

// ===== design/faar_checker.sv =====
// port-level checks for the fraction adder, bound to the top level
// depends on faar_pkg and fraction_add_and_reduce
module faar_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [faar_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  localparam int DenLo = faar_pkg::NumW;
  localparam int DenHi = faar_pkg::NumW + faar_pkg::DenW - 1;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // error result is 0/0
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result not zero");

  // good result has a nonzero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[DenHi:DenLo] != '0)
    else $error("zero denominator without error flag");

  // one item in work: ready drops after an input transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind fraction_add_and_reduce faar_checker u_faar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/fraction_add_and_reduce_tb.sv =====
// self-checking testbench for fraction_add_and_reduce: streams fraction pairs,
// predicts the reduced sums and compares every result transfer in order
// depends on faar_pkg and fraction_add_and_reduce
`timescale 1ns / 100ps

module fraction_add_and_reduce_tb;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 400;
  localparam int RandomItems   = 400;
  localparam int TailCycles    = 150;

  typedef struct packed {
    logic signed [faar_pkg::InW-1:0] b_den;
    logic signed [faar_pkg::InW-1:0] b_num;
    logic signed [faar_pkg::InW-1:0] a_den;
    logic signed [faar_pkg::InW-1:0] a_num;
  } frac_pair_t;

  typedef struct {
    logic signed [faar_pkg::NumW-1:0] num;
    logic signed [faar_pkg::DenW-1:0] den;
    logic                             err;
  } frac_sum_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [faar_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [faar_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;

  frac_pair_t pending_pairs[$];
  frac_sum_t  expected_sums[$];

  int fail_cnt    = 0;
  int n_results   = 0;
  int n_zero_den  = 0;
  int n_zero_sum  = 0;
  int n_neg_den   = 0;
  int idle_cycles = 0;

  fraction_add_and_reduce DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // a_num, a_den, b_num, b_den
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_num, out_den, zero pad
    .m_axis_tuser  (m_axis_tuser)    // zero_den_error
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic frac_pair_t make_pair(int an, int ad, int bn, int bd);
    frac_pair_t p;
    p.a_num = 16'(an);
    p.a_den = 16'(ad);
    p.b_num = 16'(bn);
    p.b_den = 16'(bd);
    return p;
  endfunction

  // cross-multiplied sum divided by the gcd of the magnitudes, signs kept
  function automatic frac_sum_t sum_reduced(frac_pair_t p);
    longint          an, ad, bn, bd, num, den;
    longint unsigned x, y, r;
    frac_sum_t       s;
    an    = p.a_num;
    ad    = p.a_den;
    bn    = p.b_num;
    bd    = p.b_den;
    num   = an * bd + bn * ad;
    den   = ad * bd;
    s.err = 1'b0;
    if (den == 0) begin
      s.num = '0;
      s.den = '0;
      s.err = 1'b1;
    end else if (num == 0) begin
      s.num = '0;
      s.den = 1;
    end else begin
      x = (num < 0) ? -num : num;
      y = (den < 0) ? -den : den;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      s.num = faar_pkg::NumW'(num / longint'(x));
      s.den = faar_pkg::DenW'(den / longint'(x));
    end
    return s;
  endfunction

  function automatic int rand_small();
    return int'($urandom_range(0, 40)) - 20;
  endfunction

  // driver: bursts of random length with random gaps in between
  int         burst_left;
  int         gap_left;
  logic       nxt_valid;
  frac_pair_t nxt_pair;
  logic       load_pair;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    = 4;
      gap_left      = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      load_pair = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_sums.push_back(sum_reduced(frac_pair_t'(s_axis_tdata)));
        nxt_valid = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pairs.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_pair  = pending_pairs.pop_front();
          load_pair = 1'b1;
        end
      end
      s_axis_tvalid <= nxt_valid;
      if (load_pair) begin
        s_axis_tdata <= nxt_pair;
      end
    end
  end

  // monitor: checks each result transfer and drives the receiver stalls
  int                               rx_cycle;
  int                               hold_left;
  logic                             hold_done;
  logic                             nxt_ready;
  frac_sum_t                        want;
  logic signed [faar_pkg::NumW-1:0] got_num;
  logic signed [faar_pkg::DenW-1:0] got_den;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_cycle      = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      rx_cycle++;
      if (m_axis_tvalid && m_axis_tready) begin
        got_num = m_axis_tdata[faar_pkg::NumW-1:0];
        got_den = m_axis_tdata[faar_pkg::NumW +: faar_pkg::DenW];
        n_results++;
        if (expected_sums.size() == 0) begin
          $display("%0t: result with nothing expected, got %0d/%0d err %0b",
                   $time, got_num, got_den, m_axis_tuser);
          fail_cnt++;
        end else begin
          want = expected_sums.pop_front();
          if (want.err) n_zero_den++;
          else if (want.num == 0) n_zero_sum++;
          else if (want.den < 0) n_neg_den++;
          if (got_num !== want.num) begin
            $display("%0t: out_num expected %0d, got %0d", $time, want.num, got_num);
            fail_cnt++;
          end
          if (got_den !== want.den) begin
            $display("%0t: out_den expected %0d, got %0d", $time, want.den, got_den);
            fail_cnt++;
          end
          if (m_axis_tuser !== want.err) begin
            $display("%0t: zero_den_error expected %0b, got %0b",
                     $time, want.err, m_axis_tuser);
            fail_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (!hold_done && n_results >= 60) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles;
        nxt_ready = 1'b0;
      end else begin
        case ((rx_cycle / 256) % 4)
          0: nxt_ready = 1'b1;
          1: nxt_ready = ($urandom_range(0, 1) == 1);
          2: nxt_ready = (rx_cycle % 4 == 0);
          default: nxt_ready = ($urandom_range(0, 9) != 0);
        endcase
      end
      m_axis_tready <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int an, ad, bn, bd, kind;

    pending_pairs.push_back(make_pair(1, 2, 1, 3));
    pending_pairs.push_back(make_pair(1, 2, -1, 2));
    pending_pairs.push_back(make_pair(0, 1, 0, 1));
    pending_pairs.push_back(make_pair(1, 0, 1, 2));
    pending_pairs.push_back(make_pair(1, 2, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, -3, 1, -3));
    pending_pairs.push_back(make_pair(1, -2, 1, 3));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 32767, 32767, -32768));
    pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767));
    pending_pairs.push_back(make_pair(32767, 1, 32767, 1));
    pending_pairs.push_back(make_pair(-32768, 1, -32768, 1));
    pending_pairs.push_back(make_pair(1, 32767, 1, -32768));
    pending_pairs.push_back(make_pair(6, 4, 10, 8));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1));
    pending_pairs.push_back(make_pair(0, -5, 0, 7));
    pending_pairs.push_back(make_pair(12345, -6789, -4321, 9876));
    pending_pairs.push_back(make_pair(-32768, 0, 32767, -32768));
    pending_pairs.push_back(make_pair(3, 6, 0, -32768));

    for (int i = 0; i < RandomItems; i++) begin
      kind = $urandom_range(0, 9);
      an   = $urandom_range(0, 65535);
      ad   = $urandom_range(0, 65535);
      bn   = $urandom_range(0, 65535);
      bd   = $urandom_range(0, 65535);
      if (kind == 0) begin
        // small values reduce often
        an = rand_small();
        ad = rand_small();
        bn = rand_small();
        bd = rand_small();
      end else if (kind == 1) begin
        if ($urandom_range(0, 1) == 1) ad = 0;
        else bd = 0;
      end else if (kind == 2) begin
        // opposite fractions sum to zero
        bn = -an;
        bd = ad;
      end else if (kind == 3) begin
        // common factors in both operands
        an = an % 256 * 6;
        ad = ad % 256 * 6;
        bn = bn % 256 * 4;
        bd = bd % 256 * 4;
      end
      pending_pairs.push_back(make_pair(an, ad, bn, bd));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("checked %0d sums: %0d zero denominator, %0d zero sum, %0d negative denominator",
             n_results, n_zero_den, n_zero_sum, n_neg_den);
    $display("receiver held off for %0d cycles once, with %0d mismatches", HoldOffCycles,
             fail_cnt);
    if (fail_cnt == 0 && expected_sums.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/faar_pkg.sv
design/faar_ctrl.sv
design/faar_dp.sv
design/fraction_add_and_reduce.sv
design/faar_checker.sv
tb/fraction_add_and_reduce_tb.sv
